>>> sv/ers_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ers_pkg
// Shared types, codes and constants of the encoder roundtrip sequencer.
// ----------------------------------------------------------------------------
package ers_pkg;

    localparam int CFG_COUNT   = 8;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 4;
    localparam int EV_W        = 14;
    localparam int DIV_STEPS   = 32;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // register indexes
    localparam logic [2:0] REG_ARM_DELAY   = 3'd0;
    localparam logic [2:0] REG_FWD_DRIVE   = 3'd1;
    localparam logic [2:0] REG_SETTLE      = 3'd2;
    localparam logic [2:0] REG_REV_PAUSE   = 3'd3;
    localparam logic [2:0] REG_REV_TIMEOUT = 3'd4;
    localparam logic [2:0] REG_LEFT_TOL    = 3'd5;
    localparam logic [2:0] REG_RIGHT_SLOW  = 3'd6;
    localparam logic [2:0] REG_RIGHT_LEAD  = 3'd7;

    // event bits
    localparam int EV_READY      = 0;
    localparam int EV_ARMING     = 1;
    localparam int EV_FWD_START  = 2;
    localparam int EV_FWD_STOP   = 3;
    localparam int EV_FWD_DONE   = 4;
    localparam int EV_LOW_LEFT   = 5;
    localparam int EV_REV_START  = 6;
    localparam int EV_LEFT_REACH = 7;
    localparam int EV_RIGHT_SLOW = 8;
    localparam int EV_RIGHT_STOP = 9;
    localparam int EV_REV_STOP   = 10;
    localparam int EV_RESULT     = 11;
    localparam int EV_SUMMARY    = 12;
    localparam int EV_ABORT      = 13;

    // wheel flag bits
    localparam int WF_LDONE = 0;
    localparam int WF_RDONE = 1;
    localparam int WF_LPUB  = 2;
    localparam int WF_RPUB  = 3;
    localparam int WF_LOW   = 4;

    localparam logic [2:0] CAUSE_NONE    = 3'd0;
    localparam logic [2:0] CAUSE_RX      = 3'd1;
    localparam logic [2:0] CAUSE_FWD_BAD = 3'd2;
    localparam logic [2:0] CAUSE_DIR     = 3'd3;
    localparam logic [2:0] CAUSE_REV_TO  = 3'd4;

    localparam logic [1:0] BRAKE_FAST = 2'd0;
    localparam logic [1:0] BRAKE_SLOW = 2'd1;
    localparam logic [1:0] BRAKE_DONE = 2'd2;

    localparam logic [7:0] DRV_LEFT_FWD   = 8'd60;
    localparam logic [7:0] DRV_RIGHT_FWD  = 8'd120;
    localparam logic [7:0] DRV_LEFT_REV   = 8'hC4;  // -60
    localparam logic [7:0] DRV_RIGHT_REV  = 8'h88;  // -120
    localparam logic [7:0] DRV_RIGHT_SLOW = 8'h9C;  // -100

    localparam logic [31:0] MIN_FRAMES     = 32'd20;
    localparam logic [31:0] AGE_READY      = 32'd100;
    localparam logic [31:0] AGE_DRIVE      = 32'd200;
    localparam logic [31:0] DIR_LIMIT      = 32'd50;
    localparam logic [31:0] LOW_LEFT_LIMIT = 32'd10;
    localparam logic [31:0] REPORT_MS      = 32'd1000;
    localparam logic [31:0] PERMILLE       = 32'd1000;

    typedef enum logic [3:0] {
        PH_WAIT    = 4'd0,
        PH_ARM     = 4'd1,
        PH_FWD     = 4'd2,
        PH_FSET    = 4'd3,
        PH_PAUSE   = 4'd4,
        PH_REV     = 4'd5,
        PH_RSET    = 4'd6,
        PH_DONE    = 4'd7,
        PH_ABORT   = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_MUL,
        S_DLOAD,
        S_DIV,
        S_DSTORE,
        S_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic mul;
        logic dload;
        logic dstep;
        logic dstore;
        logic side;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic out_free;
    } status_t;

    function automatic logic [CFG_W-1:0] cfg_reset(input logic [2:0] idx);
        logic [CFG_W-1:0] v;
        case (idx)
            REG_ARM_DELAY:   v = 16'd5000;
            REG_FWD_DRIVE:   v = 16'd300;
            REG_SETTLE:      v = 16'd800;
            REG_REV_PAUSE:   v = 16'd300;
            REG_REV_TIMEOUT: v = 16'd2500;
            REG_LEFT_TOL:    v = 16'd5;
            REG_RIGHT_SLOW:  v = 16'd500;
            REG_RIGHT_LEAD:  v = 16'd60;
            default:         v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] cfg_mask(input logic [2:0] idx);
        logic [CFG_W-1:0] v;
        case (idx)
            REG_LEFT_TOL: v = 16'h03FF;
            default:      v = 16'hFFFF;
        endcase
        return v;
    endfunction

endpackage

>>> sv/ers_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ers_ctrl
// Sequencer: one step per item, then two shared divisions when results land.
// ----------------------------------------------------------------------------
module ers_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  ers_pkg::status_t status,
    output ers_pkg::cmd_t    cmd
);

    ers_pkg::ctrl_state_t state_reg, state_next;
    logic [ers_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic side_reg, side_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ers_pkg::S_IDLE;
            cnt_reg   <= '0;
            side_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            side_reg  <= side_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        side_next  = side_reg;
        cmd        = '0;
        cmd.side   = side_reg;
        in_stall   = (state_reg != ers_pkg::S_IDLE);
        case (state_reg)
            ers_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ers_pkg::S_STEP;
                end
            end
            ers_pkg::S_STEP:
            begin
                cmd.step = 1'b1;
                side_next = 1'b0;
                state_next = status.need_div ? ers_pkg::S_MUL : ers_pkg::S_EMIT;
            end
            ers_pkg::S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ers_pkg::S_DLOAD;
            end
            ers_pkg::S_DLOAD:
            begin
                cmd.dload  = 1'b1;
                cnt_next   = '0;
                state_next = ers_pkg::S_DIV;
            end
            ers_pkg::S_DIV:
            begin
                cmd.dstep = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == ers_pkg::DIV_CNT_W'(ers_pkg::DIV_STEPS - 1))
                begin
                    state_next = ers_pkg::S_DSTORE;
                end
            end
            ers_pkg::S_DSTORE:
            begin
                cmd.dstore = 1'b1;
                if (side_reg)
                begin
                    state_next = ers_pkg::S_EMIT;
                end
                else
                begin
                    side_next  = 1'b1;
                    state_next = ers_pkg::S_MUL;
                end
            end
            ers_pkg::S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ers_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ers_pkg::S_IDLE;
            end
        endcase
    end

    a_step_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ers_pkg::S_STEP |=> state_reg != ers_pkg::S_STEP)
        else $error("step issued twice for one item");

endmodule

>>> sv/ers_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ers_dp
// Datapath: sequencer state, per-tick step logic, per-mille divider, output.
// ----------------------------------------------------------------------------
module ers_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ers_pkg::cmd_t                 cmd,
    output ers_pkg::status_t              status,
    input  logic                          cfg_we,
    input  logic [ers_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ers_pkg::CFG_W-1:0]     cfg_data,
    input  logic [31:0]                   now_ms,
    input  logic [31:0]                   rx_valid_count,
    input  logic [31:0]                   last_rx_ms,
    input  logic signed [31:0]            left_total,
    input  logic signed [31:0]            right_total,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [7:0]             left_drive,
    output logic signed [7:0]             right_drive,
    output logic [3:0]                    phase,
    output logic [13:0]                   event_flags,
    output logic [2:0]                    abort_cause,
    output logic                          result_ready,
    output logic signed [31:0]            target_left,
    output logic signed [31:0]            target_right,
    output logic signed [31:0]            error_left,
    output logic signed [31:0]            error_right,
    output logic signed [31:0]            error_left_permille,
    output logic signed [31:0]            error_right_permille
);

    logic [ers_pkg::CFG_W-1:0] cfg_reg [ers_pkg::CFG_COUNT];

    // captured item
    logic [31:0] now_reg, cnt_reg, lrx_reg, lt_reg, rt_reg;

    ers_pkg::phase_t phase_reg, phase_next;
    logic [31:0] phase_start_reg, phase_start_next;
    logic [31:0] baseline_reg, baseline_next;
    logic [31:0] last_arming_reg, last_arming_next;
    logic [31:0] last_summary_reg, last_summary_next;
    logic [31:0] fsl_reg, fsl_next, fsr_reg, fsr_next;
    logic [31:0] rsl_reg, rsl_next, rsr_reg, rsr_next;
    logic [31:0] rev_ms_reg, rev_ms_next;
    logic [31:0] tgt_l_reg, tgt_l_next, tgt_r_reg, tgt_r_next;
    logic [31:0] err_l_reg, err_l_next, err_r_reg, err_r_next;
    logic [31:0] perm_l_reg, perm_r_reg;
    logic [4:0]  wf_reg, wf_next;
    logic [1:0]  brake_reg, brake_next;
    logic [2:0]  abort_reg, abort_next;
    logic        valid_reg, valid_next;

    logic [ers_pkg::EV_W-1:0] ev_reg, ev_next;
    logic [7:0] ld_reg, ld_next, rd_reg, rd_next;

    // divider
    logic [31:0] mul_reg;
    logic [31:0] dq_reg, dd_reg, drem_reg;
    logic        dneg_reg, dzero_reg;
    logic [31:0] mul_op, mul_next;
    logic [32:0] shifted, trial;
    logic [31:0] quo_signed;

    logic out_valid_reg;
    logic need_div;

    // step scratch
    logic [31:0] el, rx_age, base, tl, tr, rl, rr, rem, left_goal, rev_el, err_l_calc;
    logic        fresh100, fresh200;

    // cfg registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ers_pkg::CFG_COUNT; i++)
            begin
                cfg_reg[i] <= ers_pkg::cfg_reset(3'(i));
            end
        end
        else if (cfg_we && cfg_index < ers_pkg::CFG_IDX_W'(ers_pkg::CFG_COUNT))
        begin
            cfg_reg[cfg_index[2:0]] <= cfg_data & ers_pkg::cfg_mask(cfg_index[2:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg <= now_ms;
            cnt_reg <= rx_valid_count;
            lrx_reg <= last_rx_ms;
            lt_reg  <= left_total;
            rt_reg  <= right_total;
        end
    end

    always_comb
    begin
        el        = now_reg - phase_start_reg;
        rx_age    = now_reg - lrx_reg;
        fresh100  = (cnt_reg != '0) && (rx_age <= ers_pkg::AGE_READY);
        fresh200  = (cnt_reg != '0) && (rx_age <= ers_pkg::AGE_DRIVE);
        base      = (baseline_reg == '0) ? cnt_reg : baseline_reg;
        tl        = lt_reg - fsl_reg;
        tr        = rt_reg - fsr_reg;
        rl        = lt_reg - rsl_reg;
        rr        = rt_reg - rsr_reg;
        rem       = tgt_r_reg + rr;
        left_goal = 32'd0 - (tgt_l_reg - {22'b0, cfg_reg[ers_pkg::REG_LEFT_TOL][9:0]});
        rev_el    = now_reg - rev_ms_reg;
        err_l_calc = tgt_l_reg + rl;

        phase_next        = phase_reg;
        phase_start_next  = phase_start_reg;
        baseline_next     = baseline_reg;
        last_arming_next  = last_arming_reg;
        last_summary_next = last_summary_reg;
        fsl_next          = fsl_reg;
        fsr_next          = fsr_reg;
        rsl_next          = rsl_reg;
        rsr_next          = rsr_reg;
        rev_ms_next       = rev_ms_reg;
        tgt_l_next        = tgt_l_reg;
        tgt_r_next        = tgt_r_reg;
        err_l_next        = err_l_reg;
        err_r_next        = err_r_reg;
        wf_next           = wf_reg;
        brake_next        = brake_reg;
        abort_next        = abort_reg;
        valid_next        = valid_reg;
        ev_next           = '0;
        ld_next           = '0;
        rd_next           = '0;
        need_div          = 1'b0;

        if ((phase_reg == ers_pkg::PH_FWD || phase_reg == ers_pkg::PH_REV) && !fresh200)
        begin
            abort_next = ers_pkg::CAUSE_RX;
            phase_next = ers_pkg::PH_ABORT;
            ev_next[ers_pkg::EV_ABORT] = 1'b1;
        end
        else
        begin
            case (phase_reg)
                ers_pkg::PH_WAIT:
                begin
                    baseline_next = base;
                    if ((cnt_reg - base) >= ers_pkg::MIN_FRAMES && fresh100)
                    begin
                        phase_next       = ers_pkg::PH_ARM;
                        phase_start_next = now_reg;
                        last_arming_next = now_reg;
                        ev_next[ers_pkg::EV_READY] = 1'b1;
                    end
                end
                ers_pkg::PH_ARM:
                begin
                    if (el >= {16'b0, cfg_reg[ers_pkg::REG_ARM_DELAY]})
                    begin
                        phase_next       = ers_pkg::PH_FWD;
                        phase_start_next = now_reg;
                        fsl_next         = lt_reg;
                        fsr_next         = rt_reg;
                        ev_next[ers_pkg::EV_FWD_START] = 1'b1;
                        ld_next = ers_pkg::DRV_LEFT_FWD;
                        rd_next = ers_pkg::DRV_RIGHT_FWD;
                    end
                    else if ((now_reg - last_arming_reg) >= ers_pkg::REPORT_MS)
                    begin
                        last_arming_next = now_reg;
                        ev_next[ers_pkg::EV_ARMING] = 1'b1;
                    end
                end
                ers_pkg::PH_FWD:
                begin
                    if (el >= {16'b0, cfg_reg[ers_pkg::REG_FWD_DRIVE]})
                    begin
                        phase_next       = ers_pkg::PH_FSET;
                        phase_start_next = now_reg;
                        ev_next[ers_pkg::EV_FWD_STOP] = 1'b1;
                    end
                    else
                    begin
                        ld_next = ers_pkg::DRV_LEFT_FWD;
                        rd_next = ers_pkg::DRV_RIGHT_FWD;
                    end
                end
                ers_pkg::PH_FSET:
                begin
                    if (el >= {16'b0, cfg_reg[ers_pkg::REG_SETTLE]})
                    begin
                        tgt_l_next = tl;
                        tgt_r_next = tr;
                        if (tl[31] || tr[31] || tr == '0)
                        begin
                            abort_next = ers_pkg::CAUSE_FWD_BAD;
                            phase_next = ers_pkg::PH_ABORT;
                            ev_next[ers_pkg::EV_ABORT] = 1'b1;
                        end
                        else
                        begin
                            phase_next       = ers_pkg::PH_PAUSE;
                            phase_start_next = now_reg;
                            ev_next[ers_pkg::EV_FWD_DONE] = 1'b1;
                            if ($signed(tl) < $signed(ers_pkg::LOW_LEFT_LIMIT))
                            begin
                                wf_next[ers_pkg::WF_LOW] = 1'b1;
                            end
                        end
                    end
                end
                ers_pkg::PH_PAUSE:
                begin
                    if (wf_reg[ers_pkg::WF_LOW])
                    begin
                        wf_next[ers_pkg::WF_LOW] = 1'b0;
                        ev_next[ers_pkg::EV_LOW_LEFT] = 1'b1;
                    end
                    if (el >= {16'b0, cfg_reg[ers_pkg::REG_REV_PAUSE]})
                    begin
                        phase_next       = ers_pkg::PH_REV;
                        phase_start_next = now_reg;
                        rev_ms_next      = now_reg;
                        rsl_next         = lt_reg;
                        rsr_next         = rt_reg;
                        // any low-left event has already been published, so all flags clear
                        wf_next          = '0;
                        brake_next       = ers_pkg::BRAKE_FAST;
                        ev_next[ers_pkg::EV_REV_START] = 1'b1;
                        if ($signed({tgt_l_reg[31], tgt_l_reg}) <=
                            $signed({23'b0, cfg_reg[ers_pkg::REG_LEFT_TOL][9:0]}))
                        begin
                            wf_next[ers_pkg::WF_LDONE] = 1'b1;
                            wf_next[ers_pkg::WF_LPUB]  = 1'b1;
                            ev_next[ers_pkg::EV_LEFT_REACH] = 1'b1;
                        end
                    end
                end
                ers_pkg::PH_REV:
                begin
                    if ($signed(rl) > $signed(ers_pkg::DIR_LIMIT) ||
                        $signed(rr) > $signed(ers_pkg::DIR_LIMIT))
                    begin
                        abort_next = ers_pkg::CAUSE_DIR;
                        phase_next = ers_pkg::PH_ABORT;
                        ev_next[ers_pkg::EV_ABORT] = 1'b1;
                    end
                    else if (rev_el >= {16'b0, cfg_reg[ers_pkg::REG_REV_TIMEOUT]} &&
                             !(wf_reg[ers_pkg::WF_LDONE] && wf_reg[ers_pkg::WF_RDONE]))
                    begin
                        abort_next = ers_pkg::CAUSE_REV_TO;
                        phase_next = ers_pkg::PH_ABORT;
                        ev_next[ers_pkg::EV_ABORT] = 1'b1;
                    end
                    else
                    begin
                        if (!wf_reg[ers_pkg::WF_LDONE] && $signed(rl) <= $signed(left_goal))
                        begin
                            wf_next[ers_pkg::WF_LDONE] = 1'b1;
                            if (!wf_reg[ers_pkg::WF_LPUB])
                            begin
                                wf_next[ers_pkg::WF_LPUB] = 1'b1;
                                ev_next[ers_pkg::EV_LEFT_REACH] = 1'b1;
                            end
                        end
                        if (!wf_reg[ers_pkg::WF_RDONE] && brake_reg == ers_pkg::BRAKE_FAST &&
                            $signed({rem[31], rem}) <=
                            $signed({17'b0, cfg_reg[ers_pkg::REG_RIGHT_SLOW]}))
                        begin
                            brake_next = ers_pkg::BRAKE_SLOW;
                            ev_next[ers_pkg::EV_RIGHT_SLOW] = 1'b1;
                        end
                        else if (!wf_reg[ers_pkg::WF_RDONE] &&
                                 brake_reg == ers_pkg::BRAKE_SLOW &&
                                 $signed({rem[31], rem}) <=
                                 $signed({17'b0, cfg_reg[ers_pkg::REG_RIGHT_LEAD]}))
                        begin
                            wf_next[ers_pkg::WF_RDONE] = 1'b1;
                            brake_next = ers_pkg::BRAKE_DONE;
                            if (!wf_reg[ers_pkg::WF_RPUB])
                            begin
                                wf_next[ers_pkg::WF_RPUB] = 1'b1;
                                ev_next[ers_pkg::EV_RIGHT_STOP] = 1'b1;
                            end
                        end
                        if (wf_next[ers_pkg::WF_LDONE] && wf_next[ers_pkg::WF_RDONE])
                        begin
                            phase_next       = ers_pkg::PH_RSET;
                            phase_start_next = now_reg;
                            ev_next[ers_pkg::EV_REV_STOP] = 1'b1;
                        end
                        else
                        begin
                            ld_next = wf_next[ers_pkg::WF_LDONE] ? 8'd0 : ers_pkg::DRV_LEFT_REV;
                            if (wf_next[ers_pkg::WF_RDONE])
                            begin
                                rd_next = 8'd0;
                            end
                            else if (brake_next == ers_pkg::BRAKE_SLOW)
                            begin
                                rd_next = ers_pkg::DRV_RIGHT_SLOW;
                            end
                            else
                            begin
                                rd_next = ers_pkg::DRV_RIGHT_REV;
                            end
                        end
                    end
                end
                ers_pkg::PH_RSET:
                begin
                    if (el >= {16'b0, cfg_reg[ers_pkg::REG_SETTLE]})
                    begin
                        err_l_next        = err_l_calc;
                        err_r_next        = tgt_r_reg + rr;
                        valid_next        = 1'b1;
                        phase_next        = ers_pkg::PH_DONE;
                        last_summary_next = now_reg;
                        ev_next[ers_pkg::EV_RESULT] = 1'b1;
                        need_div          = 1'b1;
                    end
                end
                ers_pkg::PH_DONE:
                begin
                    if ((now_reg - last_summary_reg) >= ers_pkg::REPORT_MS)
                    begin
                        last_summary_next = now_reg;
                        ev_next[ers_pkg::EV_SUMMARY] = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= ers_pkg::PH_WAIT;
            phase_start_reg  <= '0;
            baseline_reg     <= '0;
            last_arming_reg  <= '0;
            last_summary_reg <= '0;
            fsl_reg          <= '0;
            fsr_reg          <= '0;
            rsl_reg          <= '0;
            rsr_reg          <= '0;
            rev_ms_reg       <= '0;
            tgt_l_reg        <= '0;
            tgt_r_reg        <= '0;
            err_l_reg        <= '0;
            err_r_reg        <= '0;
            perm_l_reg       <= '0;
            perm_r_reg       <= '0;
            wf_reg           <= '0;
            brake_reg        <= ers_pkg::BRAKE_FAST;
            abort_reg        <= ers_pkg::CAUSE_NONE;
            valid_reg        <= 1'b0;
            ev_reg           <= '0;
            ld_reg           <= '0;
            rd_reg           <= '0;
        end
        else
        begin
            if (cmd.step)
            begin
                phase_reg        <= phase_next;
                phase_start_reg  <= phase_start_next;
                baseline_reg     <= baseline_next;
                last_arming_reg  <= last_arming_next;
                last_summary_reg <= last_summary_next;
                fsl_reg          <= fsl_next;
                fsr_reg          <= fsr_next;
                rsl_reg          <= rsl_next;
                rsr_reg          <= rsr_next;
                rev_ms_reg       <= rev_ms_next;
                tgt_l_reg        <= tgt_l_next;
                tgt_r_reg        <= tgt_r_next;
                err_l_reg        <= err_l_next;
                err_r_reg        <= err_r_next;
                wf_reg           <= wf_next;
                brake_reg        <= brake_next;
                abort_reg        <= abort_next;
                valid_reg        <= valid_next;
                ev_reg           <= ev_next;
                ld_reg           <= ld_next;
                rd_reg           <= rd_next;
            end
            if (cmd.dstore)
            begin
                if (cmd.side)
                begin
                    perm_r_reg <= dzero_reg ? 32'd0 : quo_signed;
                end
                else
                begin
                    perm_l_reg <= dzero_reg ? 32'd0 : quo_signed;
                end
            end
        end
    end

    // per-mille: err * 1000 wrapped, then signed divide truncating toward zero
    assign mul_op     = cmd.side ? err_r_reg : err_l_reg;
    assign mul_next   = 32'(mul_op * ers_pkg::PERMILLE);
    assign shifted    = {drem_reg, dq_reg[31]};
    assign trial      = shifted - {1'b0, dd_reg};
    assign quo_signed = dneg_reg ? (32'd0 - dq_reg) : dq_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            mul_reg <= mul_next;
        end
        if (cmd.dload)
        begin
            logic [31:0] den;
            den       = cmd.side ? tgt_r_reg : tgt_l_reg;
            dq_reg    <= mul_reg[31] ? (32'd0 - mul_reg) : mul_reg;
            dd_reg    <= den[31] ? (32'd0 - den) : den;
            drem_reg  <= '0;
            dneg_reg  <= mul_reg[31] ^ den[31];
            dzero_reg <= (den == '0);
        end
        else if (cmd.dstep)
        begin
            if (!trial[32])
            begin
                drem_reg <= trial[31:0];
                dq_reg   <= {dq_reg[30:0], 1'b1};
            end
            else
            begin
                drem_reg <= shifted[31:0];
                dq_reg   <= {dq_reg[30:0], 1'b0};
            end
        end
    end

    // output register
    assign status = '{need_div: need_div, out_free: (!out_valid_reg || !out_stall)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            left_drive           <= ld_reg;
            right_drive          <= rd_reg;
            phase                <= phase_reg;
            event_flags          <= ev_reg;
            abort_cause          <= abort_reg;
            result_ready         <= valid_reg;
            target_left          <= tgt_l_reg;
            target_right         <= tgt_r_reg;
            error_left           <= err_l_reg;
            error_right          <= err_r_reg;
            error_left_permille  <= perm_l_reg;
            error_right_permille <= perm_r_reg;
        end
    end

    assign out_valid = out_valid_reg;

    a_valid_in_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg) |-> phase_reg == ers_pkg::PH_DONE)
        else $error("result flagged outside done phase");

    a_cause_only_abort: assert property (@(posedge clk) disable iff (!rst_n)
        abort_reg != ers_pkg::CAUSE_NONE |-> phase_reg == ers_pkg::PH_ABORT)
        else $error("abort cause set without abort phase");

    a_div_excl_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dstep |-> !cmd.step && !cmd.emit)
        else $error("divider step overlaps step or emit");

endmodule

>>> sv/encoder_roundtrip_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_roundtrip_sequencer_unit
// Forward/reverse roundtrip test sequencer for a two-wheel drive.
// ----------------------------------------------------------------------------
// One item per millisecond tick; each tick yields one item with both motor
// commands, phase, event mask and results. A plain tick runs from accept to
// output through capture, step and emit. The tick that finishes the final
// settle runs two per-mille divisions on one shared radix-2 divider, each
// made of multiply, load, 32 iterations and store.
// The input stalls while a tick is being worked; a finished item waits in the
// output register while the next tick is accepted.
module encoder_roundtrip_sequencer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ers_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ers_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [31:0]                   now_ms,
    input  logic [31:0]                   rx_valid_count,
    input  logic [31:0]                   last_rx_ms,
    input  logic signed [31:0]            left_total,
    input  logic signed [31:0]            right_total,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [7:0]             left_drive,
    output logic signed [7:0]             right_drive,
    output logic [3:0]                    phase,
    output logic [13:0]                   event_flags,
    output logic [2:0]                    abort_cause,
    output logic                          result_ready,
    output logic signed [31:0]            target_left,
    output logic signed [31:0]            target_right,
    output logic signed [31:0]            error_left,
    output logic signed [31:0]            error_right,
    output logic signed [31:0]            error_left_permille,
    output logic signed [31:0]            error_right_permille
);

    ers_pkg::cmd_t    cmd;
    ers_pkg::status_t status;

    ers_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ers_dp u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .status               (status),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .now_ms               (now_ms),
        .rx_valid_count       (rx_valid_count),
        .last_rx_ms           (last_rx_ms),
        .left_total           (left_total),
        .right_total          (right_total),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .left_drive           (left_drive),
        .right_drive          (right_drive),
        .phase                (phase),
        .event_flags          (event_flags),
        .abort_cause          (abort_cause),
        .result_ready         (result_ready),
        .target_left          (target_left),
        .target_right         (target_right),
        .error_left           (error_left),
        .error_right          (error_right),
        .error_left_permille  (error_left_permille),
        .error_right_permille (error_right_permille)
    );

endmodule
